// ===== hw/rtl/pid_line_follow_dock_step_assert.svh =====
// Assertion macros shared by the line follower RTL.
`ifndef PID_LINE_FOLLOW_DOCK_STEP_ASSERT_SVH
`define PID_LINE_FOLLOW_DOCK_STEP_ASSERT_SVH

// Check that holds in the same cycle as its condition.
`define PLFD_ASSERT_NOW(lbl, clk, rst_n, cond, check) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (check)) \
		else $error("plfd: same-cycle check failed");

// Check that holds in the cycle after its condition.
`define PLFD_ASSERT_NEXT(lbl, clk, rst_n, cond, check) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (check)) \
		else $error("plfd: next-cycle check failed");

`endif

// ===== hw/rtl/plfd_pkg.sv =====
// Types, constants and codes shared by the line follower modules.
`timescale 1ns / 1ps

package plfd_pkg;

	localparam int POS_W      = 12;
	localparam int SENSOR_W   = 10;
	localparam int ERR_W      = 12;
	localparam int DERIV_W    = 13;
	localparam int SUM_W      = 32;
	localparam int POWER_W    = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;

	// Error is position minus the centre, limited so it fits ERR_W bits.
	localparam logic signed [POS_W+1:0] CENTRE_POS = 14'sd2000;
	localparam logic signed [POS_W+1:0] ERR_LIMIT  = 14'sd2047;

	// Integral term: divide the magnitude by 16, then by 625 through a reciprocal.
	localparam int SUM_PRE_SHIFT   = 4;
	localparam int SUM_Y_W         = SUM_W - SUM_PRE_SHIFT;
	localparam int SUM_RECIP_SHIFT = 37;
	localparam int SUM_Q_W         = 18;
	localparam logic [SUM_Y_W-1:0] SUM_RECIP = 28'd219902326;

	// Proportional term: divide the magnitude by 4, then by 5 through a reciprocal.
	localparam int ERR_PRE_SHIFT   = 2;
	localparam int ERR_Y_W         = ERR_W - 1 - ERR_PRE_SHIFT;
	localparam int ERR_RECIP_W     = 8;
	localparam int ERR_RECIP_SHIFT = 10;
	localparam int ERR_Q_W         = 7;
	localparam logic [ERR_RECIP_W-1:0] ERR_RECIP = 8'd205;

	localparam int HALF_W = DERIV_W + 1;
	localparam int DIFF_W = 20;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [2:0] {
		ACT_NONE      = 3'd0,
		ACT_MOTORS    = 3'd1,
		ACT_CROSSWALK = 3'd2,
		ACT_DOCK      = 3'd3,
		ACT_HALF_LEFT = 3'd4,
		ACT_UNDOCK    = 3'd5
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DARK      = 2'd0,
		CFG_BRIGHT    = 2'd1,
		CFG_PARTIAL   = 2'd2,
		CFG_MAX_POWER = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [SENSOR_W-1:0] dark;
		logic [SENSOR_W-1:0] bright;
		logic [SENSOR_W-1:0] partial;
		logic [POWER_W-1:0]  max_power;
	} cfg_t;

	// One classified sensor scan as it waits in the queue.
	typedef struct packed {
		logic signed [ERR_W-1:0] err;
		logic                    all_dark;
		logic                    all_bright;
		logic                    left_branch;
		logic                    any_line;
		logic                    charger;
	} item_t;

	typedef struct packed {
		logic              empty;
		logic              full;
		logic [QCNT_W-1:0] count;
	} qstat_t;

endpackage

// ===== hw/rtl/pid_line_follow_dock_step.sv =====
// Items pass through the queue, the back-end stages and the output register.
// Throughput: one item per cycle while no result waits; the integral and docked
// flag update as the item leaves the queue. The back end stalls as a whole while
// a result waits; the two-entry queue keeps taking items until it fills.
// Reset clears the PID state, the docked flag, the queue and the pipeline,
// and loads the thresholds 100, 500, 200 and a maximum power of 60.
`timescale 1ns / 1ps

`include "pid_line_follow_dock_step_assert.svh"

module pid_line_follow_dock_step import plfd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [POS_W-1:0]      line_position,
	input  logic [SENSOR_W-1:0]   sensor_a,
	input  logic [SENSOR_W-1:0]   sensor_b,
	input  logic [SENSOR_W-1:0]   sensor_c,
	input  logic [SENSOR_W-1:0]   sensor_d,
	input  logic [SENSOR_W-1:0]   sensor_e,
	input  logic                  target_is_charger,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [2:0]            action,
	output logic [POWER_W-1:0]    left_power,
	output logic [POWER_W-1:0]    right_power
);

	cfg_t   cfg_q;
	qstat_t qstat;
	item_t  front_item;
	item_t  head;
	logic   push;
	logic   pop;

	// Configuration registers. The user must make writes only while the block is idle
	// (not enforced by the block) to keep thresholds and power limit steady in flight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dark      <= 10'd100;
			cfg_q.bright    <= 10'd500;
			cfg_q.partial   <= 10'd200;
			cfg_q.max_power <= 7'd60;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_DARK:      cfg_q.dark      <= cfg_data;
				CFG_BRIGHT:    cfg_q.bright    <= cfg_data;
				CFG_PARTIAL:   cfg_q.partial   <= cfg_data;
				CFG_MAX_POWER: cfg_q.max_power <= cfg_data[POWER_W-1:0];
				default: ;
			endcase
		end
	end

	// The front end sees only the input item, the thresholds and the queue status.
	// It works out the saturated line error and the sensor pattern flags, and
	// pushes the item into the queue whenever there is room.
	plfd_front u_front (
		.cfg               (cfg_q),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.line_position     (line_position),
		.sensor_a          (sensor_a),
		.sensor_b          (sensor_b),
		.sensor_c          (sensor_c),
		.sensor_d          (sensor_d),
		.sensor_e          (sensor_e),
		.target_is_charger (target_is_charger),
		.qstat             (qstat),
		.push              (push),
		.item              (front_item)
	);

	// The queue decouples the two halves, so an item can be taken while a
	// finished result is still waiting at the output.
	plfd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (front_item),
		.pop       (pop),
		.head      (head),
		.qstat     (qstat)
	);

	// The back end owns the integral, the last error and the docked flag.
	// It updates them as an item leaves the queue, then spends three more
	// stages on the divisions, the sum and the clamp, the last being the result
	// register.
	plfd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.max_power   (cfg_q.max_power),
		.head        (head),
		.qstat       (qstat),
		.pop         (pop),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.action      (action),
		.left_power  (left_power),
		.right_power (right_power)
	);

	// A steering result always drives one side at full power.
	`PLFD_ASSERT_NOW(a_motor_full_side, clk, arst_n, out_valid && (action == ACT_MOTORS), (left_power == cfg_q.max_power) || (right_power == cfg_q.max_power))
	// Every other action leaves both motor powers at zero.
	`PLFD_ASSERT_NOW(a_other_powers_zero, clk, arst_n, out_valid && (action != ACT_MOTORS), (left_power == '0) && (right_power == '0))
	// An accepted item is in the queue on the next cycle.
	`PLFD_ASSERT_NEXT(a_push_fills_queue, clk, arst_n, in_valid && in_ready, !qstat.empty)

endmodule

// ===== hw/rtl/plfd_front.sv =====
// Front end: takes sensor scans and classifies them against the thresholds.
`timescale 1ns / 1ps

module plfd_front import plfd_pkg::*; (
	input  cfg_t                cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [POS_W-1:0]    line_position,
	input  logic [SENSOR_W-1:0] sensor_a,
	input  logic [SENSOR_W-1:0] sensor_b,
	input  logic [SENSOR_W-1:0] sensor_c,
	input  logic [SENSOR_W-1:0] sensor_d,
	input  logic [SENSOR_W-1:0] sensor_e,
	input  logic                target_is_charger,
	input  qstat_t              qstat,
	output logic                push,
	output item_t               item
);

	logic signed [POS_W+1:0] err_wide;

	assign in_ready = !qstat.full;
	assign push     = in_valid && in_ready;
	assign err_wide = $signed({2'b00, line_position}) - CENTRE_POS;

	always_comb begin
		item.err = (err_wide > ERR_LIMIT) ? ERR_LIMIT[ERR_W-1:0] : err_wide[ERR_W-1:0];
		item.all_dark = (sensor_a < cfg.dark) && (sensor_b < cfg.dark) &&
			(sensor_c < cfg.dark) && (sensor_d < cfg.dark) && (sensor_e < cfg.dark);
		item.all_bright = (sensor_a >= cfg.bright) && (sensor_b >= cfg.bright) &&
			(sensor_c >= cfg.bright) && (sensor_d >= cfg.bright) &&
			(sensor_e >= cfg.bright);
		item.left_branch = (sensor_a >= cfg.bright) && (sensor_b >= cfg.partial) &&
			(sensor_e < cfg.dark);
		item.any_line = (sensor_b > cfg.dark) || (sensor_c > cfg.dark) ||
			(sensor_d > cfg.dark);
		item.charger = target_is_charger;
	end

endmodule

// ===== hw/rtl/plfd_queue.sv =====
// Short queue of classified items between the front end and the back end.
`timescale 1ns / 1ps

module plfd_queue import plfd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  item_t  push_item,
	input  logic   pop,
	output item_t  head,
	output qstat_t qstat
);

	item_t             slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		next_ptr = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign head        = slot_q[rd_ptr_q];
	assign qstat.empty = (count_q == '0);
	assign qstat.full  = (count_q == QCNT_W'(QDEPTH));
	assign qstat.count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ===== hw/rtl/plfd_back.sv =====
// Back end: PID state, pipelined drive difference and action decision.
`timescale 1ns / 1ps

module plfd_back import plfd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [POWER_W-1:0] max_power,
	input  item_t              head,
	input  qstat_t             qstat,
	output logic               pop,
	input  logic               out_ready,
	output logic               out_valid,
	output logic [2:0]         action,
	output logic [POWER_W-1:0] left_power,
	output logic [POWER_W-1:0] right_power
);

	logic advance;

	// PID state
	logic signed [SUM_W-1:0] error_sum_q;
	logic signed [ERR_W-1:0] prev_err_q;
	logic                    docked_q;

	// Stage 1: state update
	logic signed [SUM_W:0]     sum_wide;
	logic signed [SUM_W-1:0]   sum_sat;
	logic signed [DERIV_W-1:0] deriv;
	action_t                   act_a;
	logic                      valid_s1;
	action_t                   act_s1;
	logic                      any_line_s1;
	logic signed [SUM_W-1:0]   sum_s1;
	logic signed [ERR_W-1:0]   err_s1;
	logic signed [DERIV_W-1:0] deriv_s1;

	// Stage 2: reciprocal products
	logic [SUM_W-1:0]               sum_mag;
	logic [ERR_W-1:0]               err_bits;
	logic [ERR_W-1:0]               err_mag;
	logic signed [HALF_W:0]         d_ext;
	logic signed [HALF_W:0]         triple;
	logic signed [HALF_W:0]         rounded;
	logic                           valid_s2;
	action_t                        act_s2;
	logic                           any_line_s2;
	logic                           sum_neg_s2;
	logic                           err_neg_s2;
	logic [2*SUM_Y_W-1:0]           prod_sum_s2;
	logic [ERR_Y_W+ERR_RECIP_W-1:0] prod_err_s2;
	logic signed [HALF_W-1:0]       half_s2;

	// Stage 3: drive difference
	logic [SUM_Q_W-1:0]       q_sum;
	logic [ERR_Q_W-1:0]       q_err;
	logic signed [DIFF_W-1:0] t_sum;
	logic signed [DIFF_W-1:0] t_err;
	logic signed [DIFF_W-1:0] t_half;
	logic                     valid_s3;
	action_t                  act_s3;
	logic                     any_line_s3;
	logic signed [DIFF_W-1:0] diff_s3;

	// Output register
	logic [DIFF_W-1:0]  diff_bits;
	logic [DIFF_W-1:0]  diff_mag;
	logic [POWER_W-1:0] clamped;
	action_t            act_o;
	logic [POWER_W-1:0] left_o;
	logic [POWER_W-1:0] right_o;
	logic               out_valid_q;
	action_t            action_q;
	logic [POWER_W-1:0] left_q;
	logic [POWER_W-1:0] right_q;

	assign advance     = !out_valid_q || out_ready;
	assign pop         = advance && !qstat.empty;
	assign out_valid   = out_valid_q;
	assign action      = action_q;
	assign left_power  = left_q;
	assign right_power = right_q;

	// Stage 1 logic: integral with saturation, derivative and item class.
	always_comb begin
		sum_wide = {error_sum_q[SUM_W-1], error_sum_q} +
			{{(SUM_W + 1 - ERR_W){head.err[ERR_W-1]}}, head.err};
		if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
			sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}} : {1'b0, {(SUM_W - 1){1'b1}}};
		end else begin
			sum_sat = sum_wide[SUM_W-1:0];
		end
		deriv = {head.err[ERR_W-1], head.err} - {prev_err_q[ERR_W-1], prev_err_q};
		priority if (docked_q) begin
			act_a = head.charger ? ACT_NONE : ACT_UNDOCK;
		end else if (head.all_dark) begin
			act_a = ACT_CROSSWALK;
		end else if (head.all_bright) begin
			act_a = head.charger ? ACT_DOCK : ACT_HALF_LEFT;
		end else if (head.left_branch) begin
			act_a = ACT_HALF_LEFT;
		end else begin
			// Steering; resolved to no action later if the difference is nil or no line is seen.
			act_a = ACT_MOTORS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_sum_q <= '0;
			prev_err_q  <= '0;
			docked_q    <= 1'b0;
		end else if (pop) begin
			if (!docked_q) begin
				error_sum_q <= sum_sat;
				prev_err_q  <= head.err;
			end
			if (act_a == ACT_UNDOCK) begin
				docked_q <= 1'b0;
			end else if (act_a == ACT_DOCK) begin
				docked_q <= 1'b1;
			end
		end
	end

	// Stage 2 logic: magnitudes for the reciprocal multipliers and 3/2 of the derivative.
	always_comb begin
		sum_mag  = sum_s1[SUM_W-1] ? (~sum_s1 + 1'b1) : sum_s1;
		err_bits = err_s1;
		err_mag  = err_bits[ERR_W-1] ? (~err_bits + 1'b1) : err_bits;
		d_ext    = {{(HALF_W + 1 - DERIV_W){deriv_s1[DERIV_W-1]}}, deriv_s1};
		triple   = d_ext + (d_ext <<< 1);
		rounded  = triple + {{HALF_W{1'b0}}, triple[HALF_W]};
	end

	// Stage 3 logic: quotients back to signed terms, then summed.
	always_comb begin
		q_sum  = prod_sum_s2[SUM_RECIP_SHIFT +: SUM_Q_W];
		q_err  = prod_err_s2[ERR_RECIP_SHIFT +: ERR_Q_W];
		t_sum  = {{(DIFF_W - SUM_Q_W){1'b0}}, q_sum};
		t_err  = {{(DIFF_W - ERR_Q_W){1'b0}}, q_err};
		t_half = {{(DIFF_W - HALF_W){half_s2[HALF_W-1]}}, half_s2};
		if (sum_neg_s2) begin
			t_sum = -t_sum;
		end
		if (err_neg_s2) begin
			t_err = -t_err;
		end
	end

	// Output logic: clamp to max_power and pick the motor powers.
	always_comb begin
		diff_bits = diff_s3;
		diff_mag  = diff_bits[DIFF_W-1] ? (~diff_bits + 1'b1) : diff_bits;
		clamped   = (diff_mag > {{(DIFF_W - POWER_W){1'b0}}, max_power}) ?
			max_power : diff_mag[POWER_W-1:0];
		act_o   = act_s3;
		left_o  = '0;
		right_o = '0;
		if (act_s3 == ACT_MOTORS) begin
			if ((clamped == '0) || !any_line_s3) begin
				act_o = ACT_NONE;
			end else if (diff_bits[DIFF_W-1]) begin
				left_o  = max_power - clamped;
				right_o = max_power;
			end else begin
				left_o  = max_power;
				right_o = max_power - clamped;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1    <= pop;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			act_s1      <= act_a;
			any_line_s1 <= head.any_line;
			sum_s1      <= sum_sat;
			err_s1      <= head.err;
			deriv_s1    <= deriv;

			act_s2      <= act_s1;
			any_line_s2 <= any_line_s1;
			sum_neg_s2  <= sum_s1[SUM_W-1];
			err_neg_s2  <= err_s1[ERR_W-1];
			prod_sum_s2 <= {{SUM_Y_W{1'b0}}, sum_mag[SUM_W-1:SUM_PRE_SHIFT]} *
				{{SUM_Y_W{1'b0}}, SUM_RECIP};
			prod_err_s2 <= {{ERR_RECIP_W{1'b0}}, err_mag[ERR_W-2:ERR_PRE_SHIFT]} *
				{{ERR_Y_W{1'b0}}, ERR_RECIP};
			half_s2     <= rounded[HALF_W:1];

			act_s3      <= act_s2;
			any_line_s3 <= any_line_s2;
			diff_s3     <= t_sum + t_err + t_half;

			action_q    <= act_o;
			left_q      <= left_o;
			right_q     <= right_o;
		end
	end

endmodule

// ===== bench/tb_top.sv =====
// Self-checking regression bench for the PID line follower with charger docking.
`timescale 1ns / 1ps

module tb_top;
	import plfd_pkg::*;

	// The watchdog allows for the longest gap the random idling can make, the
	// pipeline latency and the pause taken around every register write.
	localparam int WATCHDOG_LIMIT   = 2000;
	localparam int SETTLE_CYCLES    = 8;
	localparam int RANDOM_PER_PHASE = 70;
	// Items at the largest error, enough to build up a sizeable integral term.
	localparam int SATURATE_ITEMS   = 40;
	localparam int RECOVERY_ITEMS   = 20;

	localparam longint CENTRE     = 2000;
	localparam longint ERR_CEIL   = 2047;
	localparam longint P_DIVISOR  = 20;
	localparam longint I_DIVISOR  = 10000;
	localparam longint SUM_CEIL   = 64'sd2147483647;
	localparam longint SUM_FLOOR  = -64'sd2147483648;
	localparam int     LEVEL_TOP  = 1023;
	localparam int     POS_TOP    = 4095;

	// One sensor scan; level 0 is the leftmost sensor and level 4 the rightmost.
	typedef struct packed {
		logic [POS_W-1:0]              pos;
		logic [4:0][SENSOR_W-1:0]      lvl;
		logic                          charger;
	} scan_t;

	typedef struct packed {
		logic [2:0]         act;
		logic [POWER_W-1:0] left;
		logic [POWER_W-1:0] right;
	} drive_cmd_t;

	// A row of the directed table; typed rows carry a hand-written result.
	typedef struct packed {
		scan_t      scan;
		logic       typed;
		drive_cmd_t want;
	} dir_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [POS_W-1:0]      line_position = '0;
	logic [SENSOR_W-1:0]   sensor_a = '0;
	logic [SENSOR_W-1:0]   sensor_b = '0;
	logic [SENSOR_W-1:0]   sensor_c = '0;
	logic [SENSOR_W-1:0]   sensor_d = '0;
	logic [SENSOR_W-1:0]   sensor_e = '0;
	logic                  target_is_charger = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [2:0]            action;
	logic [POWER_W-1:0]    left_power;
	logic [POWER_W-1:0]    right_power;

	// Bench copy of the thresholds and of the controller state.
	logic [SENSOR_W-1:0]     thr_dark = 10'd100;
	logic [SENSOR_W-1:0]     thr_bright = 10'd500;
	logic [SENSOR_W-1:0]     thr_partial = 10'd200;
	logic [POWER_W-1:0]      pwr_max = 7'd60;
	int                      integral = 0;
	logic signed [ERR_W-1:0] last_error = '0;
	logic                    is_docked = 1'b0;
	logic [POS_W-1:0]        last_pos = 12'd2000;

	drive_cmd_t drive_cmds_due[$];
	dir_row_t   dir_tab[$];
	int         mismatches = 0;
	int         tx_idle_pct = 0;
	int         rx_idle_pct = 0;
	int unsigned stall_cycles = 0;

	pid_line_follow_dock_step DUT (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.line_position     (line_position),
		.sensor_a          (sensor_a),
		.sensor_b          (sensor_b),
		.sensor_c          (sensor_c),
		.sensor_d          (sensor_d),
		.sensor_e          (sensor_e),
		.target_is_charger (target_is_charger),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.action            (action),
		.left_power        (left_power),
		.right_power       (right_power)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Works out the drive command for one accepted scan and advances the bench
	// copy of the integral, the last error and the docked flag.
	function automatic drive_cmd_t next_drive_cmd(scan_t s);
		longint     err;
		longint     deriv;
		longint     total;
		longint     diff;
		longint     lim;
		logic       dark_all;
		logic       bright_all;
		logic       line_seen;
		drive_cmd_t cmd;
		int         i;

		cmd.act = ACT_NONE;
		cmd.left = '0;
		cmd.right = '0;
		dark_all = 1'b1;
		bright_all = 1'b1;
		for (i = 0; i < 5; i++) begin
			if (s.lvl[i] >= thr_dark)
				dark_all = 1'b0;
			if (s.lvl[i] < thr_bright)
				bright_all = 1'b0;
		end

		// While docked the PID state is frozen; only leaving the charger matters.
		if (is_docked) begin
			if (!s.charger) begin
				is_docked = 1'b0;
				cmd.act = ACT_UNDOCK;
			end
			return cmd;
		end

		// The error is limited above so that it fits the stored last error.
		err = longint'(s.pos) - CENTRE;
		if (err > ERR_CEIL)
			err = ERR_CEIL;
		deriv = err - longint'(last_error);
		total = longint'(integral) + err;
		if (total > SUM_CEIL)
			total = SUM_CEIL;
		if (total < SUM_FLOOR)
			total = SUM_FLOOR;
		integral = int'(total);
		last_error = ERR_W'(err);

		// Each quotient truncates toward zero before the terms are added.
		lim = longint'(pwr_max);
		diff = err / P_DIVISOR + total / I_DIVISOR + (deriv * 3) / 2;
		if (diff > lim)
			diff = lim;
		if (diff < -lim)
			diff = -lim;

		if (dark_all) begin
			cmd.act = ACT_CROSSWALK;
		end else if (bright_all) begin
			if (s.charger) begin
				is_docked = 1'b1;
				cmd.act = ACT_DOCK;
			end else begin
				cmd.act = ACT_HALF_LEFT;
			end
		end else if (s.lvl[0] >= thr_bright && s.lvl[1] >= thr_partial &&
				s.lvl[4] < thr_dark) begin
			cmd.act = ACT_HALF_LEFT;
		end else begin
			line_seen = s.lvl[2] > thr_dark || s.lvl[3] > thr_dark || s.lvl[1] > thr_dark;
			if (diff < 0 && line_seen) begin
				cmd.act = ACT_MOTORS;
				cmd.left = POWER_W'(lim + diff);
				cmd.right = POWER_W'(lim);
			end else if (diff > 0 && line_seen) begin
				cmd.act = ACT_MOTORS;
				cmd.left = POWER_W'(lim);
				cmd.right = POWER_W'(lim - diff);
			end
		end
		return cmd;
	endfunction

	function automatic dir_row_t dir_row(int pos, int a, int b, int c, int d, int e,
			logic chg, logic typed, logic [2:0] act, int lp, int rp);
		dir_row_t r;

		r.scan.pos = POS_W'(pos);
		r.scan.lvl[0] = SENSOR_W'(a);
		r.scan.lvl[1] = SENSOR_W'(b);
		r.scan.lvl[2] = SENSOR_W'(c);
		r.scan.lvl[3] = SENSOR_W'(d);
		r.scan.lvl[4] = SENSOR_W'(e);
		r.scan.charger = chg;
		r.typed = typed;
		r.want.act = act;
		r.want.left = POWER_W'(lp);
		r.want.right = POWER_W'(rp);
		return r;
	endfunction

	// A level just under, at or just over a threshold, or anywhere at all.
	function automatic logic [SENSOR_W-1:0] level_near(logic [SENSOR_W-1:0] th);
		int v;

		case ($urandom_range(3))
			0: v = int'(th) - 1;
			1: v = int'(th);
			2: v = int'(th) + 1;
			default: v = $urandom_range(LEVEL_TOP);
		endcase
		if (v < 0)
			v = 0;
		if (v > LEVEL_TOP)
			v = LEVEL_TOP;
		return SENSOR_W'(v);
	endfunction

	function automatic logic [SENSOR_W-1:0] level_below(logic [SENSOR_W-1:0] th);
		if (th == 0)
			return '0;
		return SENSOR_W'($urandom_range(int'(th) - 1, 0));
	endfunction

	// Scans are shaped against the current thresholds so that every branch of
	// the sensor decision is visited, with a share of unshaped noise.
	function automatic scan_t random_scan();
		scan_t s;
		int    pick;
		int    i;

		pick = $urandom_range(99);
		for (i = 0; i < 5; i++) begin
			if (pick < 10)
				s.lvl[i] = level_below(thr_dark);
			else if (pick < 25)
				s.lvl[i] = SENSOR_W'($urandom_range(LEVEL_TOP, int'(thr_bright)));
			else if (pick < 85) begin
				case ($urandom_range(2))
					0: s.lvl[i] = level_near(thr_dark);
					1: s.lvl[i] = level_near(thr_bright);
					default: s.lvl[i] = level_near(thr_partial);
				endcase
			end else
				s.lvl[i] = SENSOR_W'($urandom_range(LEVEL_TOP));
		end
		// Left branch: bright far left, partial second sensor, dark far right.
		if (pick >= 25 && pick < 35) begin
			s.lvl[0] = SENSOR_W'($urandom_range(LEVEL_TOP, int'(thr_bright)));
			s.lvl[1] = SENSOR_W'($urandom_range(LEVEL_TOP, int'(thr_partial)));
			s.lvl[4] = level_below(thr_dark);
		end

		case ($urandom_range(9))
			0: s.pos = POS_W'(CENTRE);
			1: s.pos = last_pos;
			2: s.pos = POS_W'($urandom_range(POS_TOP));
			3: s.pos = POS_W'($urandom_range(POS_TOP, 4040));
			4: s.pos = POS_W'($urandom_range(100));
			default: s.pos = POS_W'($urandom_range(2400, 1600));
		endcase
		last_pos = s.pos;
		s.charger = 1'($urandom_range(1));
		return s;
	endfunction

	// Presents one scan and holds it until the block takes it. The expected
	// command is worked out at the accepting edge, with the thresholds in force.
	task automatic send_scan(scan_t s, logic typed, drive_cmd_t want);
		drive_cmd_t due;

		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		line_position <= s.pos;
		sensor_a <= s.lvl[0];
		sensor_b <= s.lvl[1];
		sensor_c <= s.lvl[2];
		sensor_d <= s.lvl[3];
		sensor_e <= s.lvl[4];
		target_is_charger <= s.charger;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		due = next_drive_cmd(s);
		if (typed)
			due = want;
		drive_cmds_due.push_back(due);
	endtask

	// Every item yields a result, so once none is outstanding the block is idle;
	// a further wait of SETTLE_CYCLES follows for good measure.
	task automatic settle();
		in_valid <= 1'b0;
		while (drive_cmds_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	// Writes all four registers on consecutive edges, keeping the enable high.
	task automatic set_config(int dark, int bright, int partial, int maxp);
		cfg_we <= 1'b1;
		cfg_index <= CFG_DARK;
		cfg_data <= CFG_DATA_W'(dark);
		@(posedge clk);
		cfg_index <= CFG_BRIGHT;
		cfg_data <= CFG_DATA_W'(bright);
		@(posedge clk);
		cfg_index <= CFG_PARTIAL;
		cfg_data <= CFG_DATA_W'(partial);
		@(posedge clk);
		cfg_index <= CFG_MAX_POWER;
		cfg_data <= CFG_DATA_W'(maxp);
		@(posedge clk);
		cfg_we <= 1'b0;
		thr_dark = SENSOR_W'(dark);
		thr_bright = SENSOR_W'(bright);
		thr_partial = SENSOR_W'(partial);
		pwr_max = POWER_W'(maxp);
	endtask

	task automatic random_phase(int dark, int bright, int partial, int maxp);
		int n;

		settle();
		set_config(dark, bright, partial, maxp);
		for (n = 0; n < RANDOM_PER_PHASE; n++)
			send_scan(random_scan(), 1'b0, '0);
	endtask

	// The receiver stalls at random according to the current idling mode.
	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= rx_idle_pct);

	// Results are checked in order against the oldest outstanding command.
	always @(posedge clk) begin : result_check
		drive_cmd_t want;

		if (arst_n && out_valid && out_ready) begin
			if (drive_cmds_due.size() == 0) begin
				$display("%0t: result with no item outstanding: action %0d left %0d right %0d",
					$time, action, left_power, right_power);
				mismatches++;
			end else begin
				want = drive_cmds_due.pop_front();
				if (action !== want.act) begin
					$display("%0t: action mismatch, expected %0d, actual %0d",
						$time, want.act, action);
					mismatches++;
				end
				if (left_power !== want.left) begin
					$display("%0t: left power mismatch, expected %0d, actual %0d",
						$time, want.left, left_power);
					mismatches++;
				end
				if (right_power !== want.right) begin
					$display("%0t: right power mismatch, expected %0d, actual %0d",
						$time, want.right, right_power);
					mismatches++;
				end
			end
		end
	end

	// The watchdog ends a run in which nothing moves on either channel.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("pid_line_follow_dock_step regression: fail");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int k;
		scan_t fixed;

		// Directed rows run with the reset thresholds 100, 500, 200 and power 60.
		// All dark, then all bright without and with the charger as target.
		dir_tab.push_back(dir_row(2000, 0, 0, 0, 0, 0, 1'b0, 1'b1, ACT_CROSSWALK, 0, 0));
		dir_tab.push_back(dir_row(2000, 1000, 1000, 1000, 1000, 1000, 1'b0, 1'b1,
			ACT_HALF_LEFT, 0, 0));
		dir_tab.push_back(dir_row(2000, 1023, 1023, 1023, 1023, 1023, 1'b1, 1'b1,
			ACT_DOCK, 0, 0));
		// Docked: the charger still targeted does nothing, another target undocks.
		dir_tab.push_back(dir_row(4095, 1023, 1023, 1023, 1023, 1023, 1'b1, 1'b1,
			ACT_NONE, 0, 0));
		dir_tab.push_back(dir_row(4095, 0, 0, 0, 0, 0, 1'b0, 1'b1, ACT_UNDOCK, 0, 0));
		// Left branch, including its exact threshold edges and a charger target.
		dir_tab.push_back(dir_row(2000, 1000, 300, 0, 0, 0, 1'b0, 1'b1, ACT_HALF_LEFT, 0, 0));
		dir_tab.push_back(dir_row(2000, 1000, 300, 0, 0, 0, 1'b1, 1'b1, ACT_HALF_LEFT, 0, 0));
		dir_tab.push_back(dir_row(2000, 500, 200, 0, 0, 99, 1'b0, 1'b1, ACT_HALF_LEFT, 0, 0));
		// Position past the top of the range saturates the error; both clamps follow.
		dir_tab.push_back(dir_row(4095, 0, 0, 600, 0, 0, 1'b0, 1'b1, ACT_MOTORS, 60, 0));
		dir_tab.push_back(dir_row(0, 0, 0, 600, 0, 0, 1'b0, 1'b1, ACT_MOTORS, 0, 60));
		// Inner sensors exactly at the dark level count as no line.
		dir_tab.push_back(dir_row(0, 0, 100, 100, 100, 0, 1'b0, 1'b1, ACT_NONE, 0, 0));
		dir_tab.push_back(dir_row(2000, 0, 0, 600, 0, 0, 1'b0, 1'b1, ACT_MOTORS, 60, 0));
		// Centred twice in a row: the difference is zero.
		dir_tab.push_back(dir_row(2000, 0, 0, 600, 0, 0, 1'b0, 1'b1, ACT_NONE, 0, 0));
		dir_tab.push_back(dir_row(2010, 0, 0, 0, 101, 0, 1'b0, 1'b0, ACT_NONE, 0, 0));
		dir_tab.push_back(dir_row(1990, 0, 101, 0, 0, 0, 1'b1, 1'b0, ACT_NONE, 0, 0));
		// Exactly at the bright level is bright; one under the dark level is dark.
		dir_tab.push_back(dir_row(4000, 500, 500, 500, 500, 500, 1'b0, 1'b1,
			ACT_HALF_LEFT, 0, 0));
		dir_tab.push_back(dir_row(0, 99, 99, 99, 99, 99, 1'b1, 1'b1, ACT_CROSSWALK, 0, 0));
		// Left branch missed by one on the far right and on the second sensor.
		dir_tab.push_back(dir_row(2100, 1000, 1000, 0, 0, 100, 1'b0, 1'b0, ACT_NONE, 0, 0));
		dir_tab.push_back(dir_row(1900, 1000, 199, 0, 0, 0, 1'b0, 1'b0, ACT_NONE, 0, 0));
		dir_tab.push_back(dir_row(4095, 1023, 0, 1023, 0, 1023, 1'b0, 1'b0, ACT_NONE, 0, 0));
		dir_tab.push_back(dir_row(2000, 1023, 0, 0, 0, 0, 1'b0, 1'b0, ACT_NONE, 0, 0));
		// A second dock, hold and undock.
		dir_tab.push_back(dir_row(1500, 600, 600, 600, 600, 600, 1'b1, 1'b1, ACT_DOCK, 0, 0));
		dir_tab.push_back(dir_row(2500, 0, 0, 0, 0, 0, 1'b1, 1'b1, ACT_NONE, 0, 0));
		dir_tab.push_back(dir_row(2500, 0, 0, 0, 0, 0, 1'b0, 1'b1, ACT_UNDOCK, 0, 0));

		tx_idle_pct = 20;
		rx_idle_pct = 45;
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < dir_tab.size(); k++)
			send_scan(dir_tab[k].scan, dir_tab[k].typed, dir_tab[k].want);

		// Random phases: the reset values, the extremes and random settings, under
		// each idling mode in turn.
		random_phase(100, 500, 200, 60);
		random_phase(0, 1023, 1023, 127);
		settle();
		tx_idle_pct = 45;
		rx_idle_pct = 20;
		random_phase($urandom_range(300), $urandom_range(1000, 300), $urandom_range(1000),
			$urandom_range(127, 1));
		random_phase(1023, 0, 0, 0);
		settle();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		random_phase($urandom_range(300), $urandom_range(1000, 300), $urandom_range(1000),
			$urandom_range(127, 1));
		random_phase($urandom_range(300), $urandom_range(1000, 300), $urandom_range(1000),
			$urandom_range(127, 1));

		// A run at the largest error builds up the integral, then the error swings
		// to its floor and the integral term unwinds against the other two.
		settle();
		set_config(100, 500, 200, 127);
		fixed.pos = POS_W'(POS_TOP);
		fixed.lvl = '0;
		fixed.lvl[2] = 10'd600;
		fixed.charger = 1'b0;
		for (k = 0; k < SATURATE_ITEMS; k++)
			send_scan(fixed, 1'b0, '0);
		fixed.pos = '0;
		for (k = 0; k < RECOVERY_ITEMS; k++)
			send_scan(fixed, 1'b0, '0);

		settle();
		if (mismatches == 0)
			$display("pid_line_follow_dock_step regression: pass");
		else
			$display("pid_line_follow_dock_step regression: fail");
		$finish;
	end

endmodule
